// File: hdl/assert_macros.svh
// Assertion macros shared by the console writer modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TMCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// When the first expression holds, the second must hold in the next cycle.
`define TMCW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tmcw_pkg.sv
// Shared types and constants of the text-mode console writer.
// No dependencies; the module files refer to it by scoped names.
package tmcw_pkg;

  // Field widths.
  localparam int POS_W  = 11;
  localparam int CHAR_W = 8;
  localparam int OPC_W  = 2;

  // Attribute stored in every cell after reset.
  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'd7;

  // Request opcodes.
  localparam logic [OPC_W-1:0] OPC_PUT   = 2'd0;
  localparam logic [OPC_W-1:0] OPC_CLEAR = 2'd1;
  localparam logic [OPC_W-1:0] OPC_READ  = 2'd2;

  // Bytes that start a new line.
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;

  // Configuration register index, taken from paddr[2].
  localparam logic REG_CELL_ATTR = 1'b0;

  // Command queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // Classified command kinds.
  typedef enum logic [2:0] {
    CMD_PUT     = 3'd0,
    CMD_NEWLINE = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_READ    = 3'd3,
    CMD_NOP     = 3'd4
  } cmd_op_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    cmd_op_t             op;
    logic [CHAR_W-1:0]   ch;
    logic [POS_W-1:0]    idx;
    logic                hit;
  } cmd_t;

endpackage

// File: hdl/tmcw_front.sv
// Front end of the console writer: accepts requests and classifies them.
// Depends on tmcw_pkg; feeds tmcw_queue.
module tmcw_front #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tmcw_pkg::OPC_W-1:0]  in_opcode,
  input  logic [tmcw_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tmcw_pkg::POS_W-1:0]  in_cell_index,
  input  logic                        q_full,
  input  logic                        init_busy,
  output logic                        q_push,
  output tmcw_pkg::cmd_t              q_cmd
);

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int XW    = (CW > tmcw_pkg::POS_W) ? CW : tmcw_pkg::POS_W;

  logic is_newline;

  // Take a request only once the screen store is initialized and the queue has room.
  assign in_ready = !init_busy && !q_full;
  assign q_push   = in_valid && in_ready;

  // Sort the request into the kind of work the back end performs.
  assign is_newline = (in_char_code == tmcw_pkg::CHAR_LF) ||
                      (in_char_code == tmcw_pkg::CHAR_CR);

  always_comb begin
    q_cmd.ch  = in_char_code;
    q_cmd.idx = in_cell_index;
    q_cmd.hit = XW'(in_cell_index) < XW'(CELLS);
    case (in_opcode)
      tmcw_pkg::OPC_PUT: begin
        q_cmd.op = is_newline ? tmcw_pkg::CMD_NEWLINE : tmcw_pkg::CMD_PUT;
      end
      tmcw_pkg::OPC_CLEAR: begin
        q_cmd.op = tmcw_pkg::CMD_CLEAR;
      end
      tmcw_pkg::OPC_READ: begin
        q_cmd.op = tmcw_pkg::CMD_READ;
      end
      default: begin
        q_cmd.op = tmcw_pkg::CMD_NOP;
      end
    endcase
  end

  `include "assert_macros.svh"

  // No request enters while the store is being initialized.
  `TMCW_ASSERT(a_no_push_in_init, !(q_push && init_busy), "push during init")
  // A pushed command never lands in a full queue.
  `TMCW_ASSERT(a_no_push_full, !(q_push && q_full), "push into full queue")
  // A read flagged in range names a real cell.
  `TMCW_ASSERT(a_hit_range, !q_cmd.hit || (int'(in_cell_index) < CELLS), "bad range flag")

endmodule

// File: hdl/tmcw_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on tmcw_pkg for the command type and depth.
module tmcw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tmcw_pkg::cmd_t push_cmd,
  input  logic           pop,
  output tmcw_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           empty
);

  tmcw_pkg::cmd_t                slot_r [tmcw_pkg::Q_DEPTH];
  logic [tmcw_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [tmcw_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [tmcw_pkg::Q_PTR_W:0]    count_r, count_nxt;

  assign full     = count_r == (tmcw_pkg::Q_PTR_W + 1)'(tmcw_pkg::Q_DEPTH);
  assign empty    = count_r == '0;
  assign head_cmd = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hdl/tmcw_back.sv
// Back end of the console writer: cursor, screen store, scroll and clear sweeps.
// Depends on tmcw_pkg and assert_macros.svh; takes commands from tmcw_queue.
module tmcw_back #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tmcw_pkg::cmd_t              q_cmd,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic [tmcw_pkg::CHAR_W-1:0] cell_attribute,
  output logic                        init_busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tmcw_pkg::POS_W-1:0]  out_cursor_position,
  output logic [tmcw_pkg::CHAR_W-1:0] out_read_char,
  output logic [tmcw_pkg::CHAR_W-1:0] out_read_attribute
);

  localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int KEEP   = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int COLW   = $clog2(SCREEN_COLUMNS);
  localparam int ROWW   = $clog2(SCREEN_ROWS);
  localparam int CELL_W = 2 * tmcw_pkg::CHAR_W;

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_COPY  = 5'b00100,
    ST_BLANK = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [AW-1:0]               cnt_r, cnt_nxt;
  logic [COLW-1:0]             col_r, col_nxt;
  logic [ROWW-1:0]             row_r, row_nxt;
  logic [AW-1:0]               base_r, base_nxt;
  logic                        rd_hit_r, rd_hit_nxt;
  logic [COLW:0]               col_inc;
  logic                        newline;
  logic [AW-1:0]               pos;

  // Screen store, read and write paths.
  logic [CELL_W-1:0]           mem [CELLS];
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [CELL_W-1:0]           rd_data_r;
  logic                        wr_req;
  logic [AW-1:0]               wr_addr_req;
  logic                        wr_copy_req;
  logic [CELL_W-1:0]           wr_data_req;
  logic                        wr_en_r;
  logic [AW-1:0]               wr_addr_r;
  logic                        wr_copy_r;
  logic [CELL_W-1:0]           wr_data_r;

  // Result register.
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_load;
  logic [tmcw_pkg::POS_W-1:0]  out_pos_r;
  logic [tmcw_pkg::CHAR_W-1:0] out_char_r;
  logic [tmcw_pkg::CHAR_W-1:0] out_attr_r;

  assign pos       = base_r + AW'(col_r);
  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign init_busy = state_r == ST_INIT;

  // Sequencer: dispatches commands and walks the store for init, scroll and clear.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    base_nxt    = base_r;
    rd_hit_nxt  = rd_hit_r;
    newline     = 1'b0;
    q_pop       = 1'b0;
    out_load    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cnt_r + AW'(SCREEN_COLUMNS);
    wr_req      = 1'b0;
    wr_addr_req = cnt_r;
    wr_copy_req = 1'b0;
    wr_data_req = {{tmcw_pkg::CHAR_W{1'b0}}, cell_attribute};
    case (state_r)
      ST_INIT: begin
        wr_req      = 1'b1;
        wr_data_req = {{tmcw_pkg::CHAR_W{1'b0}}, tmcw_pkg::ATTR_RESET};
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          rd_hit_nxt = 1'b0;
          state_nxt  = ST_DONE;
          case (q_cmd.op)
            tmcw_pkg::CMD_PUT: begin
              wr_req      = 1'b1;
              wr_addr_req = pos;
              wr_data_req = {q_cmd.ch, cell_attribute};
              if (col_inc == (COLW + 1)'(SCREEN_COLUMNS)) begin
                newline = 1'b1;
              end else begin
                col_nxt = col_inc[COLW-1:0];
              end
            end
            tmcw_pkg::CMD_NEWLINE: begin
              newline = 1'b1;
            end
            tmcw_pkg::CMD_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              base_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = ST_BLANK;
            end
            tmcw_pkg::CMD_READ: begin
              rd_hit_nxt = q_cmd.hit;
              rd_en      = q_cmd.hit;
              rd_addr    = AW'(q_cmd.idx);
            end
            default: begin
            end
          endcase
          // Next line, or scroll when already on the bottom row.
          if (newline) begin
            col_nxt = '0;
            if (row_r != ROWW'(SCREEN_ROWS - 1)) begin
              row_nxt  = row_r + 1'b1;
              base_nxt = base_r + AW'(SCREEN_COLUMNS);
            end else begin
              cnt_nxt   = '0;
              state_nxt = ST_COPY;
            end
          end
        end
      end
      ST_COPY: begin
        // Read one row below, write the cell in the next cycle.
        rd_en       = 1'b1;
        wr_req      = 1'b1;
        wr_copy_req = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == AW'(KEEP - 1)) begin
          state_nxt = ST_BLANK;
        end
      end
      ST_BLANK: begin
        wr_req = 1'b1;
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      cnt_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      base_r   <= '0;
      rd_hit_r <= 1'b0;
      wr_en_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      base_r   <= base_nxt;
      rd_hit_r <= rd_hit_nxt;
      wr_en_r  <= wr_req;
    end
  end

  // Registered write request; a copy takes the data read in the previous cycle.
  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_req;
    wr_copy_r <= wr_copy_req;
    wr_data_r <= wr_data_req;
  end

  // Screen store with one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en_r) begin
      mem[wr_addr_r] <= wr_copy_r ? rd_data_r : wr_data_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Output register holds the result until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_r  <= tmcw_pkg::POS_W'(pos);
      out_char_r <= rd_hit_r ? rd_data_r[CELL_W-1:tmcw_pkg::CHAR_W] : '0;
      out_attr_r <= rd_hit_r ? rd_data_r[tmcw_pkg::CHAR_W-1:0] : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_read_char       = out_char_r;
  assign out_read_attribute  = out_attr_r;

  `include "assert_macros.svh"

  // Every store write has landed before a new command is dispatched.
  `TMCW_ASSERT(a_idle_no_write, q_pop |-> !wr_en_r, "write pending at dispatch")
  // The row base always tracks the cursor row.
  `TMCW_ASSERT(a_base_row, base_r == AW'(row_r * SCREEN_COLUMNS), "row base out of step")
  // The cursor column stays on the screen.
  `TMCW_ASSERT(a_col_range, {1'b0, col_r} < (COLW + 1)'(SCREEN_COLUMNS), "column off screen")
  // A new result appears only after a finished command.
  `TMCW_ASSERT_NXT(a_out_from_done, !out_valid_r, !out_valid_r || $past(state_r == ST_DONE),
    "result without command")

endmodule

// File: hdl/text_mode_console_writer.sv
// Text-mode console writer top level: request channel, result channel, APB register.
// Depends on tmcw_pkg, tmcw_front, tmcw_queue and tmcw_back.
//
// Usage:
//   Requests arrive on in_valid/in_ready with in_opcode, in_char_code and
//   in_cell_index (put character, clear screen, read cell). Each request yields
//   exactly one result on out_valid/out_ready carrying the cursor position and,
//   for a read, the addressed cell's character and attribute.
//   The attribute register sits at byte address 0 of the APB port.
//   Flow: a put, new line without scroll or read passes from dispatch in the
//   back-end sequencer (ST_IDLE) through its result step (ST_DONE) to the
//   registered out_valid; the back end dispatches the next request only after
//   that result step, while later requests wait in the queue.
//   A scroll copies rows up (ST_COPY) and blanks the bottom row; a clear blanks
//   all cells (ST_BLANK); sweeps write one cell per cycle via the single write port.
//   Reset: the store is initialized by a pass that writes every cell (ST_INIT);
//   in_ready stays low during that pass. Register writes are taken.
//   Stall: when out_ready is low the result is held and the back end waits;
//   up to four requests still queue behind it before in_ready drops.
module text_mode_console_writer #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tmcw_pkg::OPC_W-1:0]  in_opcode,
  input  logic [tmcw_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tmcw_pkg::POS_W-1:0]  in_cell_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tmcw_pkg::POS_W-1:0]  out_cursor_position,
  output logic [tmcw_pkg::CHAR_W-1:0] out_read_char,
  output logic [tmcw_pkg::CHAR_W-1:0] out_read_attribute,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [tmcw_pkg::CHAR_W-1:0] cell_attr_r;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_full;
  logic                        q_empty;
  logic                        init_busy;
  tmcw_pkg::cmd_t              push_cmd;
  tmcw_pkg::cmd_t              head_cmd;

  // Configuration register, written in the APB access cycle.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_attr_r <= tmcw_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == tmcw_pkg::REG_CELL_ATTR)) begin
      cell_attr_r <= pwdata[tmcw_pkg::CHAR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == tmcw_pkg::REG_CELL_ATTR) ? 32'(cell_attr_r) : '0;

  // Request classification.
  tmcw_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .q_full        (q_full),
    .init_busy     (init_busy),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // Command queue.
  tmcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Cursor, screen store and result register.
  tmcw_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_cmd               (head_cmd),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .cell_attribute      (cell_attr_r),
    .init_busy           (init_busy),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_position (out_cursor_position),
    .out_read_char       (out_read_char),
    .out_read_attribute  (out_read_attribute)
  );

endmodule
